// ----- rtl/core/pms_pkg.sv -----
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types and codes for the periodic message scheduler: command and
// status codes, the packed table entry and the sequencer states.
// ----------------------------------------------------------------------------
package pms_pkg;

    // field widths
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned ID_W     = 16;
    localparam int unsigned PER_W    = 16;
    localparam int unsigned DUE_W    = 32;
    localparam int unsigned STATUS_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // one table entry as stored in the ram
    typedef struct packed {
        logic [DUE_W-1:0] due;
        logic [PER_W-1:0] per;
        logic [ID_W-1:0]  id;
    } t_entry;

    // control for the minimum tracker, one per read data beat
    typedef struct packed {
        logic vld;
        logic first;
    } t_sel_ctl;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_FINISH
    } t_state;

endpackage

// ----- rtl/core/pms_ram.sv -----
// ----------------------------------------------------------------------------
// pms_ram
// Generic simple dual-port ram: one write port and one read port
// with a registered read.
// ----------------------------------------------------------------------------
module pms_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/pms_select.sv -----
// ----------------------------------------------------------------------------
// pms_select
// Running minimum over the entries streamed out of the table ram. Orders by
// due time, then identifier; on a full tie the earlier slot is kept.
// ----------------------------------------------------------------------------
module pms_select #(
    parameter int unsigned AW = 6
) (
    input  logic              i_clk,
    input  pms_pkg::t_sel_ctl i_ctl,
    input  logic [AW-1:0]     i_idx,
    input  pms_pkg::t_entry   i_entry,
    output logic [AW-1:0]     o_best_idx,
    output pms_pkg::t_entry   o_best
);
    import pms_pkg::*;

    logic [AW-1:0] r_best_idx;
    t_entry        r_best;
    logic          ranks_first;
    logic          take;

    // strict ordering keeps the lowest slot on a full tie
    always_comb begin
        ranks_first = (i_entry.due < r_best.due) ||
                      ((i_entry.due == r_best.due) && (i_entry.id < r_best.id));
        take        = i_ctl.vld && (i_ctl.first || ranks_first);
    end

    // best candidate so far
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_idx <= i_idx;
            r_best     <= i_entry;
        end
    end

    assign o_best_idx = r_best_idx;
    assign o_best     = r_best;

endmodule

// ----- rtl/core/periodic_message_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// periodic_message_scheduler_top
// Table of periodic users with clear, load and dispatch commands.
// ----------------------------------------------------------------------------
// One command item in, one result item out. The table lives in a single ram
// (identifier, period and due time per slot) with one read and one write port.
// Clear, load, an unused command, a dispatch on an empty table and a load into
// a full table go from accept to commit with no table read. A dispatch on a
// non-empty table reads one entry per cycle in the scan state while a running
// minimum is kept, then the wait state drains the ram read latency and the
// finish state writes the advanced due time back and posts the result. The result
// sits in an output register, so the next command is taken while it waits;
// the commit of that next command waits until the register is free. The table
// needs no clearing pass after reset: only slots below the user count are read.
// ----------------------------------------------------------------------------
module periodic_message_scheduler_top #(
    parameter int unsigned MAX_USERS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] user_id, [31:16] period
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sent_id
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import pms_pkg::*;

    localparam int unsigned AW = $clog2(MAX_USERS);
    localparam int unsigned CW = $clog2(MAX_USERS + 1);

    // registers and next values
    t_state               r_state, n_state;
    logic [CMD_W-1:0]     r_cmd, n_cmd;
    logic [ID_W-1:0]      r_uid, n_uid;
    logic [PER_W-1:0]     r_per, n_per;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_idx, n_idx;
    t_sel_ctl             r_sel, n_sel;
    logic [AW-1:0]        r_sel_idx, n_sel_idx;
    logic                 r_out_vld, n_out_vld;
    logic [ID_W-1:0]      r_out_id, n_out_id;
    logic [STATUS_W-1:0]  r_out_st, n_out_st;

    // ram and select unit wiring
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    t_entry               ram_wdata;
    logic                 ram_re;
    t_entry               ram_rdata;
    logic [AW-1:0]        best_idx;
    t_entry               best;

    logic                 out_free;
    logic                 scan_last;
    logic                 tbl_full;
    logic [DUE_W:0]       due_sum;
    logic [DUE_W-1:0]     due_next;

    pms_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_USERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    pms_select #(
        .AW (AW)
    ) u_select (
        .i_clk      (i_clk),
        .i_ctl      (r_sel),
        .i_idx      (r_sel_idx),
        .i_entry    (ram_rdata),
        .o_best_idx (best_idx),
        .o_best     (best)
    );

    // helpers
    always_comb begin
        out_free  = !r_out_vld || m_axis_tready;
        scan_last = (CW'(r_idx) + CW'(1)) == r_count;
        tbl_full  = r_count == CW'(MAX_USERS);
        due_sum   = {1'b0, best.due} + (DUE_W+1)'(best.per);
        due_next  = due_sum[DUE_W] ? {DUE_W{1'b1}} : due_sum[DUE_W-1:0];
    end

    // sequencer: next state and outputs
    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_uid         = r_uid;
        n_per         = r_per;
        n_count       = r_count;
        n_idx         = r_idx;
        n_sel         = '0;
        n_sel_idx     = r_idx;
        n_out_vld     = r_out_vld && !m_axis_tready;
        n_out_id      = r_out_id;
        n_out_st      = r_out_st;
        s_axis_tready = 1'b0;
        ram_re        = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = r_count[AW-1:0];
        ram_wdata     = '0;

        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_cmd = s_axis_tuser;
                    n_uid = s_axis_tdata[15:0];
                    n_per = s_axis_tdata[31:16];
                    n_idx = '0;
                    if (s_axis_tuser == CMD_DISPATCH && r_count != '0) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            // one table read per cycle
            S_SCAN: begin
                ram_re      = 1'b1;
                n_sel.vld   = 1'b1;
                n_sel.first = (r_idx == '0);
                if (scan_last) begin
                    n_state = S_WAIT;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            // last read data reaches the select unit
            S_WAIT: begin
                n_state = S_FINISH;
            end
            // commit side effects together with the result
            S_FINISH: begin
                if (out_free) begin
                    n_state   = S_IDLE;
                    n_out_vld = 1'b1;
                    n_out_id  = '0;
                    n_out_st  = ST_OK;
                    case (r_cmd)
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_LOAD: begin
                            if (tbl_full) begin
                                n_out_st = ST_FULL;
                            end else begin
                                ram_we        = 1'b1;
                                ram_waddr     = r_count[AW-1:0];
                                ram_wdata.id  = r_uid;
                                ram_wdata.per = r_per;
                                ram_wdata.due = DUE_W'(r_per);
                                n_count       = r_count + CW'(1);
                            end
                        end
                        CMD_DISPATCH: begin
                            if (r_count == '0) begin
                                n_out_st = ST_EMPTY;
                            end else begin
                                n_out_id      = best.id;
                                ram_we        = 1'b1;
                                ram_waddr     = best_idx;
                                ram_wdata.id  = best.id;
                                ram_wdata.per = best.per;
                                ram_wdata.due = due_next;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_sel     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_sel     <= n_sel;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_uid     <= n_uid;
        r_per     <= n_per;
        r_idx     <= n_idx;
        r_sel_idx <= n_sel_idx;
        r_out_id  <= n_out_id;
        r_out_st  <= n_out_st;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_id;
    assign m_axis_tuser  = r_out_st;

    // user count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_USERS))
        else $error("user count beyond table size");

    // a scan only runs over a non-empty table
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_count != '0))
        else $error("scan started on empty table");

    // read data beats only while a scan is draining
    a_sel_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel.vld |-> (r_state == S_SCAN || r_state == S_WAIT))
        else $error("select beat outside scan");

    // a commit always posts a result
    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && out_free) |=> m_axis_tvalid)
        else $error("commit without result");

endmodule

// ----- sim/periodic_message_scheduler_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_message_scheduler_top_tb
// Self-checking bench for the periodic message scheduler. Command items go in
// over the slave stream. A scoreboard mirrors the user table and queues the
// expected result of each accepted command. Every result item is checked
// against the oldest expected one. The bench covers empty and full tables,
// the unused command, zero periods, due-time ties, duplicate identifiers,
// a long output stall and random load/dispatch runs.
// ----------------------------------------------------------------------------
module periodic_message_scheduler_top_tb;

    import pms_pkg::*;

    localparam int unsigned USERS      = 64;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned ITEM_GOAL  = 1800;
    localparam int unsigned LONG_HOLD  = 400;
    localparam int unsigned MAX_SHOWN  = 200;

    // one expected result item
    typedef struct packed {
        logic [ID_W-1:0]     sent_id;
        logic [STATUS_W-1:0] status;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [15:0] user_id, [31:16] period
    logic [1:0]  s_axis_tuser;   // [1:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] sent_id
    logic [1:0]  m_axis_tuser;   // [1:0] status

    // scoreboard copy of the user table
    logic [ID_W-1:0]  tab_id  [USERS];
    logic [PER_W-1:0] tab_per [USERS];
    logic [DUE_W-1:0] tab_due [USERS];
    int unsigned      user_count = 0;

    t_reply      reply_queue[$];
    logic        gaps_on = 1'b1;
    int unsigned hold_left = 0;
    int unsigned mismatch_count = 0;
    int unsigned n_items = 0;
    int unsigned n_loads = 0;
    int unsigned n_dispatches = 0;
    int unsigned n_full = 0;
    int unsigned n_empty = 0;
    int unsigned n_results = 0;

    periodic_message_scheduler_top #(
        .MAX_USERS(USERS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // table update and expected result for one command
    function automatic t_reply schedule_step(input logic [CMD_W-1:0] cmd,
                                             input logic [ID_W-1:0] uid,
                                             input logic [PER_W-1:0] per);
        t_reply          r;
        int unsigned     best;
        logic [DUE_W:0]  sum;
        r.sent_id = '0;
        r.status  = ST_OK;
        case (cmd)
            CMD_CLEAR: begin
                user_count = 0;
            end
            CMD_LOAD: begin
                if (user_count >= USERS) begin
                    r.status = ST_FULL;
                end else begin
                    tab_id[user_count]  = uid;
                    tab_per[user_count] = per;
                    tab_due[user_count] = DUE_W'(per);
                    user_count++;
                end
            end
            CMD_DISPATCH: begin
                if (user_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // earliest due wins, then smaller id, then lowest slot
                    best = 0;
                    for (int k = 1; k < user_count; k++) begin
                        if (tab_due[k] < tab_due[best] ||
                            (tab_due[k] == tab_due[best] && tab_id[k] < tab_id[best]))
                            best = k;
                    end
                    r.sent_id = tab_id[best];
                    sum = {1'b0, tab_due[best]} + (DUE_W+1)'(tab_per[best]);
                    tab_due[best] = sum[DUE_W] ? '1 : sum[DUE_W-1:0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // compare one result item with the oldest expectation
    task automatic check_reply(input logic [ID_W-1:0] got_id,
                               input logic [STATUS_W-1:0] got_st);
        t_reply want;
        if (reply_queue.size() == 0) begin
            report_mismatch($sformatf("result id %h status %0d with none pending",
                                      got_id, got_st));
        end else begin
            want = reply_queue.pop_front();
            n_results++;
            if (got_id !== want.sent_id)
                report_mismatch($sformatf("sent_id %h, expected %h", got_id, want.sent_id));
            if (got_st !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", got_st, want.status));
        end
    endtask

    // one command item, with an optional random gap before it
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] uid,
                            input logic [PER_W-1:0] per);
        int unsigned gap;
        t_reply      r;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {per, uid};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        r = schedule_step(cmd, uid, per);
        reply_queue.push_back(r);
        if (cmd != CMD_UNUSED)
            n_items++;
        if (cmd == CMD_LOAD)
            n_loads++;
        if (cmd == CMD_DISPATCH)
            n_dispatches++;
        if (r.status == ST_FULL)
            n_full++;
        if (r.status == ST_EMPTY)
            n_empty++;
    endtask

    // stop sending and let every pending result come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (reply_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [ID_W-1:0] random_id();
        // a narrow range now and then so that identifiers repeat
        return ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 7))
                                           : ID_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [PER_W-1:0] random_period();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '0;
        else if (pick < 9)
            return PER_W'($urandom_range(1, 8));
        else
            return PER_W'($urandom_range(1, 65535));
    endfunction

    // result side: random stalls plus an optional long hold
    initial begin
        int unsigned stall;
        stall = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                check_reply(m_axis_tdata, m_axis_tuser);
                stall = gaps_on ? $urandom_range(0, 7) : 0;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // empty table and unused command
    task automatic test_empty_and_unused();
        send_cmd(CMD_DISPATCH, 16'h1234, 16'h0001);
        send_cmd(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_UNUSED, 16'h0000, 16'h0000);
        send_cmd(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_DISPATCH, 16'hFFFF, 16'hFFFF);
        drain_results();
    endtask

    // identifier and period extremes, zero period
    task automatic test_field_extremes();
        send_cmd(CMD_CLEAR, 16'h0000, 16'h0000);
        send_cmd(CMD_LOAD, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_LOAD, 16'h0000, 16'h0001);
        send_cmd(CMD_DISPATCH, 16'h0000, 16'h0000);
        send_cmd(CMD_LOAD, 16'h8001, 16'h0000);
        send_cmd(CMD_DISPATCH, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_DISPATCH, 16'h0000, 16'h0000);
        send_cmd(CMD_UNUSED, 16'h5A5A, 16'hA5A5);
        send_cmd(CMD_DISPATCH, 16'h0000, 16'h0000);
        send_cmd(CMD_CLEAR, 16'h0000, 16'h0000);
        send_cmd(CMD_DISPATCH, 16'h0000, 16'h0000);
        drain_results();
    endtask

    // equal due times and duplicate identifiers
    task automatic test_ties();
        send_cmd(CMD_LOAD, 16'd5, 16'd3);
        send_cmd(CMD_LOAD, 16'd2, 16'd3);
        send_cmd(CMD_LOAD, 16'd5, 16'd3);
        send_cmd(CMD_LOAD, 16'd9, 16'd1);
        repeat (8) send_cmd(CMD_DISPATCH, 16'd0, 16'd0);
        send_cmd(CMD_CLEAR, 16'd0, 16'd0);
        drain_results();
    endtask

    // fill the table and load past the end
    task automatic test_full_table();
        send_cmd(CMD_CLEAR, 16'd0, 16'd0);
        repeat (USERS) send_cmd(CMD_LOAD, random_id(), PER_W'($urandom_range(1, 4)));
        send_cmd(CMD_LOAD, 16'hFFFF, 16'hFFFF);
        repeat (4) send_cmd(CMD_DISPATCH, 16'd0, 16'd0);
        send_cmd(CMD_LOAD, 16'h0000, 16'h0001);
        send_cmd(CMD_CLEAR, 16'd0, 16'd0);
        send_cmd(CMD_LOAD, 16'h00AA, 16'h0002);
        send_cmd(CMD_DISPATCH, 16'd0, 16'd0);
        drain_results();
    endtask

    // long output stall while commands keep coming
    task automatic test_backpressure();
        send_cmd(CMD_CLEAR, 16'd0, 16'd0);
        repeat (4) send_cmd(CMD_LOAD, random_id(), random_period());
        hold_left <= LONG_HOLD;
        repeat (12) send_cmd(CMD_DISPATCH, 16'd0, 16'd0);
        drain_results();
    endtask

    // random episodes: clear, load a table, dispatch a burst, some noise
    task automatic test_random();
        int unsigned stop_at;
        int unsigned users;
        int unsigned pick;
        stop_at = n_items + ITEM_GOAL;
        while (n_items < stop_at) begin
            gaps_on <= ($urandom_range(0, 3) != 0);
            send_cmd(CMD_CLEAR, ID_W'($urandom_range(0, 65535)),
                     PER_W'($urandom_range(0, 65535)));
            pick = $urandom_range(0, 15);
            if (pick < 11)
                users = $urandom_range(1, 6);
            else if (pick < 15)
                users = $urandom_range(7, 40);
            else
                users = USERS + $urandom_range(0, 2);
            repeat (users) send_cmd(CMD_LOAD, random_id(), random_period());
            repeat ($urandom_range(1, 2 * users + 3)) begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    send_cmd(CMD_UNUSED, ID_W'($urandom_range(0, 65535)),
                             PER_W'($urandom_range(0, 65535)));
                else if (pick == 1)
                    send_cmd(CMD_LOAD, random_id(), random_period());
                else
                    send_cmd(CMD_DISPATCH, ID_W'($urandom_range(0, 65535)),
                             PER_W'($urandom_range(0, 65535)));
            end
            // broken sequence: dispatch straight after a clear
            if ($urandom_range(0, 7) == 0) begin
                send_cmd(CMD_CLEAR, 16'd0, 16'd0);
                send_cmd(CMD_DISPATCH, ID_W'($urandom_range(0, 65535)),
                         PER_W'($urandom_range(0, 65535)));
            end
        end
        gaps_on <= 1'b1;
        drain_results();
    endtask

    // main sequence
    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_CLEAR;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_unused();
        test_field_extremes();
        test_ties();
        test_full_table();
        test_backpressure();
        test_random();

        $display("covered %0d commands: %0d loads, %0d dispatches, %0d results checked",
                 n_items, n_loads, n_dispatches, n_results);
        $display("table-full loads %0d, empty-table dispatches %0d, mismatches %0d",
                 n_full, n_empty, mismatch_count);
        if (mismatch_count == 0 && reply_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(60_000_000);
        $display("timeout with %0d results pending", reply_queue.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
